FILE: design/assert_macros.svh
// Assertion macros for the RTL, included by the top-level design file.
// Each check samples on the rising clock edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a property holds, with the antecedent given in the property.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`endif

`endif

FILE: design/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

  // Register access codes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLR   = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Control register bit positions
  localparam int unsigned CTL_AA  = 2;
  localparam int unsigned CTL_SI  = 3;
  localparam int unsigned CTL_STO = 4;
  localparam int unsigned CTL_STA = 5;

  // Status codes
  localparam logic [7:0] ST_IDLE       = 8'hF8;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_AW_ACK     = 8'h18;
  localparam logic [7:0] ST_AW_NAK     = 8'h20;
  localparam logic [7:0] ST_DW_ACK     = 8'h28;
  localparam logic [7:0] ST_DW_NAK     = 8'h30;
  localparam logic [7:0] ST_AR_ACK     = 8'h40;
  localparam logic [7:0] ST_AR_NAK     = 8'h48;
  localparam logic [7:0] ST_DR_ACK     = 8'h50;
  localparam logic [7:0] ST_DR_NAK     = 8'h58;

  // Bus event codes
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_ADDR       = 3'd1;
  localparam logic [2:0] EV_WRITE      = 3'd2;
  localparam logic [2:0] EV_READ       = 3'd3;
  localparam logic [2:0] EV_STOP       = 3'd4;
  localparam logic [2:0] EV_RESTART    = 3'd5;
  localparam logic [2:0] EV_STOP_START = 3'd6;

  typedef struct packed {
    logic [1:0] op;
    logic       port;
    logic [7:0] value;
    logic       target_present;
    logic       target_ack;
    logic [7:0] target_read_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] control_out;
    logic [7:0] status_out;
    logic [7:0] data_out;
    logic [2:0] bus_event;
    logic [6:0] bus_address;
    logic       bus_read;
    logic       fault;
  } out_beat_t;

  // Register set of one port
  typedef struct packed {
    logic [7:0] control;
    logic [7:0] status;
    logic [7:0] data;
  } port_state_t;

endpackage

FILE: design/i2cms_regfile.sv
`timescale 1ns / 1ps

module i2cms_regfile #(
  parameter int NUM_PORTS = 2,
  parameter int PORT_IDX_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [PORT_IDX_W-1:0]    rd_idx_i,
  output i2cms_pkg::port_state_t   rd_state_o,
  input  logic                     wr_en_i,
  input  logic [PORT_IDX_W-1:0]    wr_idx_i,
  input  i2cms_pkg::port_state_t   wr_state_i
);
  import i2cms_pkg::*;

  port_state_t state_q [NUM_PORTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        state_q[i].control <= 8'h00;
        state_q[i].status  <= ST_IDLE;
        state_q[i].data    <= 8'h00;
      end
    end else if (wr_en_i) begin
      state_q[wr_idx_i] <= wr_state_i;
    end
  end

  assign rd_state_o = state_q[rd_idx_i];

endmodule

FILE: design/i2cms_core.sv
`timescale 1ns / 1ps

module i2cms_core (
  input  i2cms_pkg::in_beat_t     beat_i,
  input  i2cms_pkg::port_state_t  cur_i,
  output i2cms_pkg::port_state_t  nxt_o,
  output i2cms_pkg::out_beat_t    res_o
);
  import i2cms_pkg::*;

  logic [7:0] ctl_mod;
  logic [7:0] ctl_si;
  logic       sta;
  logic       sto;
  logic       ss_hit;
  logic [7:0] ss_ctl;
  logic [7:0] ss_status;
  logic [2:0] ss_ev;
  logic [2:0] ev;
  logic [6:0] addr;
  logic       rd;
  logic       fault;
  port_state_t nxt;

  // Apply the set or clear mask, then mark the interrupt pending
  assign ctl_mod = (beat_i.op == OP_SET) ? (cur_i.control | beat_i.value)
                                         : (cur_i.control & ~beat_i.value);
  assign ctl_si  = ctl_mod | (8'h01 << CTL_SI);
  assign sta     = ctl_mod[CTL_STA];
  assign sto     = ctl_mod[CTL_STO];

  // Start/stop request handling shared by the write-ack and read-nak states
  always_comb begin
    ss_hit    = sta | sto;
    ss_ctl    = ctl_si;
    ss_status = cur_i.status;
    ss_ev     = EV_NONE;
    if (sta && sto) begin
      ss_ctl    = ctl_si & ~(8'h01 << CTL_STO);
      ss_status = ST_START;
      ss_ev     = EV_STOP_START;
    end else if (sta) begin
      ss_status = ST_RESTART;
      ss_ev     = EV_RESTART;
    end else if (sto) begin
      ss_ctl    = ctl_si & ~(8'h01 << CTL_STO);
      ss_status = ST_IDLE;
      ss_ev     = EV_STOP;
    end
  end

  always_comb begin
    nxt   = cur_i;
    ev    = EV_NONE;
    addr  = 7'd0;
    rd    = 1'b0;
    fault = 1'b0;
    case (beat_i.op)
      OP_WRITE: begin
        nxt.data = beat_i.value;
      end
      OP_SET, OP_CLR: begin
        nxt.control = ctl_mod;
        if (!ctl_mod[CTL_SI]) begin
          nxt.control = ctl_si;
          case (cur_i.status)
            ST_IDLE: begin
              if (sta) nxt.status = ST_START;
            end
            ST_START: begin
              if (!sta) begin
                ev   = EV_ADDR;
                addr = cur_i.data[7:1];
                rd   = cur_i.data[0];
                if (beat_i.target_present) begin
                  nxt.status = cur_i.data[0] ? ST_AR_ACK : ST_AW_ACK;
                end else begin
                  nxt.status = cur_i.data[0] ? ST_AR_NAK : ST_AW_NAK;
                end
              end
            end
            ST_AW_ACK, ST_DW_ACK: begin
              if (ss_hit) begin
                nxt.control = ss_ctl;
                nxt.status  = ss_status;
                ev          = ss_ev;
              end else begin
                ev         = EV_WRITE;
                nxt.status = beat_i.target_ack ? ST_DW_ACK : ST_DW_NAK;
              end
            end
            ST_AR_ACK, ST_DR_ACK: begin
              ev         = EV_READ;
              rd         = ctl_mod[CTL_AA];
              nxt.data   = beat_i.target_read_byte;
              nxt.status = ctl_mod[CTL_AA] ? ST_DR_ACK : ST_DR_NAK;
            end
            ST_DR_NAK: begin
              nxt.control = ss_ctl;
              nxt.status  = ss_status;
              ev          = ss_ev;
            end
            default: begin
              fault = 1'b1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign nxt_o = nxt;

  always_comb begin
    res_o.control_out = nxt.control;
    res_o.status_out  = nxt.status;
    res_o.data_out    = nxt.data;
    res_o.bus_event   = ev;
    res_o.bus_address = addr;
    res_o.bus_read    = rd;
    res_o.fault       = fault;
  end

endmodule

FILE: design/i2c_master_status_machine.sv
`timescale 1ns / 1ps
// I2C master status-code controller, one register set per port.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat is one
// register access to one port: set control bits, clear control bits, or
// write the data register, together with the addressed target's response.
// Output channel (out_valid_o / out_ready_i / out_data_o): one beat per
// accepted access, carrying control, status and data after the access, the
// bus event code, address, direction/ack and the fault flag.
// An accepted beat waits in the input register and moves, once the result
// slot is free, into the result register. Throughput: one beat per cycle
// unless a low out_ready_i stalls; the per-port register read, one status
// transition and the write back fit between the input and result registers,
// so back to back accesses to the same port see each other's updates.
// Reset: every port returns to control 0, status 0xF8 (idle), data 0, and
// both pipeline stages empty.
// Stall: while out_ready_i is low a waiting result holds; the input register
// still takes one more beat, then in_ready_o drops until the output drains.
// An access to a port at or above NUM_PORTS leaves all state alone and
// returns an all-zero result.
`include "assert_macros.svh"

module i2c_master_status_machine #(
  parameter int NUM_PORTS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2cms_pkg::in_beat_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2cms_pkg::out_beat_t  out_data_o
);
  import i2cms_pkg::*;

  localparam int PortIdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic        in_valid_q;
  in_beat_t    in_q;
  logic        out_valid_q;
  out_beat_t   out_q;

  logic        advance;
  logic        port_ok;
  logic [PortIdxW-1:0] port_idx;
  port_state_t cur_state;
  port_state_t nxt_state;
  out_beat_t   core_res;
  out_beat_t   out_d;

  // Move the held beat into the result register when that slot is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || !out_valid_q || out_ready_i;

  assign port_idx = PortIdxW'(in_q.port);
  assign port_ok  = (32'(in_q.port) < NUM_PORTS);

  i2cms_regfile #(
    .NUM_PORTS  (NUM_PORTS),
    .PORT_IDX_W (PortIdxW)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (port_idx),
    .rd_state_o (cur_state),
    .wr_en_i    (advance && port_ok),
    .wr_idx_i   (port_idx),
    .wr_state_i (nxt_state)
  );

  i2cms_core u_core (
    .beat_i (in_q),
    .cur_i  (cur_state),
    .nxt_o  (nxt_state),
    .res_o  (core_res)
  );

  // Drop accesses to absent ports: report all zeros
  assign out_d = port_ok ? core_res : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A faulted transition never reports a bus event
  `ASSERT_PROP(a_fault_no_event, clk_i, rst_ni, (out_valid_q && out_q.fault |-> out_q.bus_event == EV_NONE), "fault with bus event")
  // Any bus event comes from a transition, which leaves SI set
  `ASSERT_PROP(a_event_sets_si, clk_i, rst_ni, (out_valid_q && out_q.bus_event != EV_NONE |-> out_q.control_out[CTL_SI]), "bus event without SI")
  // The address field is only nonzero on an address event
  `ASSERT_PROP(a_addr_only_on_addr, clk_i, rst_ni, (out_valid_q && out_q.bus_event != EV_ADDR |-> out_q.bus_address == 7'd0), "stray bus address")
  // A held input beat that cannot advance blocks new input
  `ASSERT_PROP(a_hold_blocks_input, clk_i, rst_ni, (in_valid_q && !advance |-> !in_ready_o), "input taken while stage blocked")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import i2cms_pkg::*;

  localparam int PORTS = 2;

  // Run shape: directed rows come first, then random beats. Port 0 is kept
  // out of the dead status codes until the closing stretch of the random part.
  localparam int unsigned RANDOM_BEATS = 1325;
  localparam int unsigned UNGUARDED    = 150;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned ERR_PRINTS   = 200;

  // Access code the block reports but does not act on.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Control register masks
  localparam int unsigned CTL_EN = 6;
  localparam logic [7:0] M_AA  = 8'h01 << CTL_AA;
  localparam logic [7:0] M_SI  = 8'h01 << CTL_SI;
  localparam logic [7:0] M_STO = 8'h01 << CTL_STO;
  localparam logic [7:0] M_STA = 8'h01 << CTL_STA;
  localparam logic [7:0] M_EN  = 8'h01 << CTL_EN;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_CHOKE} sink_mode_e;

  typedef struct {
    in_beat_t  acc;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;

  // Directed rows, and the results that the accepted beats still owe.
  dir_row_t    dir_rows[$];
  out_beat_t   owed_reports_q[$];

  // Two copies of the port registers: one the stimulus plans with, one the
  // scoreboard advances on each accepted input beat.
  port_state_t plan_regs [PORTS];
  port_state_t live_regs [PORTS];

  int unsigned sent_n      = 0;
  int unsigned accepted_n  = 0;
  int unsigned checked_n   = 0;
  int unsigned err_n       = 0;
  int unsigned fault_n     = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  int unsigned ev_tally [8];

  sink_mode_e  rx_mode = SINK_OPEN;
  int unsigned rx_run  = 0;

  i2c_master_status_machine #(
    .NUM_PORTS(PORTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // One register access on one port's registers. Returns the report of the
  // access and hands back the registers as they stand after it.
  function automatic out_beat_t apply_access(input port_state_t cur, input in_beat_t acc,
                                             output port_state_t upd);
    out_beat_t  r;
    logic [7:0] c;
    logic [7:0] s;
    logic [7:0] d;
    logic       sta;
    logic       sto;
    r = '0;
    c = cur.control;
    s = cur.status;
    d = cur.data;
    case (acc.op)
      OP_WRITE: d = acc.value;
      OP_SET, OP_CLR: begin
        if (acc.op == OP_SET) c = c | acc.value;
        else c = c & ~acc.value;
        // A pending interrupt blocks the transition; only the control bits move.
        if (!c[CTL_SI]) begin
          c[CTL_SI] = 1'b1;
          sta = c[CTL_STA];
          sto = c[CTL_STO];
          case (s)
            ST_IDLE: if (sta) s = ST_START;
            ST_START: begin
              if (!sta) begin
                r.bus_event   = EV_ADDR;
                r.bus_address = d[7:1];
                r.bus_read    = d[0];
                if (acc.target_present) s = d[0] ? ST_AR_ACK : ST_AW_ACK;
                else s = d[0] ? ST_AR_NAK : ST_AW_NAK;
              end
            end
            ST_AW_ACK, ST_DW_ACK, ST_DR_NAK: begin
              if (sta && sto) begin
                c[CTL_STO]  = 1'b0;
                s           = ST_START;
                r.bus_event = EV_STOP_START;
              end else if (sta) begin
                s           = ST_RESTART;
                r.bus_event = EV_RESTART;
              end else if (sto) begin
                c[CTL_STO]  = 1'b0;
                s           = ST_IDLE;
                r.bus_event = EV_STOP;
              end else if (s != ST_DR_NAK) begin
                r.bus_event = EV_WRITE;
                s           = acc.target_ack ? ST_DW_ACK : ST_DW_NAK;
              end
            end
            ST_AR_ACK, ST_DR_ACK: begin
              r.bus_event = EV_READ;
              r.bus_read  = c[CTL_AA];
              d           = acc.target_read_byte;
              s           = c[CTL_AA] ? ST_DR_ACK : ST_DR_NAK;
            end
            default: r.fault = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    upd.control   = c;
    upd.status    = s;
    upd.data      = d;
    r.control_out = c;
    r.status_out  = s;
    r.data_out    = d;
    return r;
  endfunction

  function automatic in_beat_t mk_access(logic [1:0] op, logic port, logic [7:0] value,
                                         logic present, logic ack, logic [7:0] rbyte);
    in_beat_t a;
    a.op               = op;
    a.port             = port;
    a.value            = value;
    a.target_present   = present;
    a.target_ack       = ack;
    a.target_read_byte = rbyte;
    return a;
  endfunction

  function automatic out_beat_t mk_report(logic [7:0] c, logic [7:0] s, logic [7:0] d,
                                          logic [2:0] ev, logic [6:0] addr, logic rd,
                                          logic flt);
    out_beat_t r;
    r.control_out = c;
    r.status_out  = s;
    r.data_out    = d;
    r.bus_event   = ev;
    r.bus_address = addr;
    r.bus_read    = rd;
    r.fault       = flt;
    return r;
  endfunction

  // Draw a random access: mostly well-formed control traffic with random
  // content, plus some pure noise that may carry the unused access code.
  function automatic in_beat_t draw_access();
    in_beat_t    a;
    logic [31:0] raw;
    logic [31:0] pick;
    raw    = $urandom;
    pick   = $urandom;
    a      = raw[$bits(in_beat_t)-1:0];
    a.port = (pick[7:0] < 8'd38) ? 1'b1 : 1'b0;
    if (pick[15:8] >= 8'd26) begin
      case (pick[17:16])
        2'd0: a.op = OP_WRITE;
        2'd1: begin
          a.op    = OP_SET;
          a.value = a.value & (M_AA | M_STA | M_STO | M_EN);
        end
        default: begin
          a.op    = OP_CLR;
          a.value = M_SI | (a.value & (M_AA | M_STA | M_STO));
        end
      endcase
    end
    return a;
  endfunction

  task automatic add_row(input in_beat_t a, input bit typed = 1'b0,
                         input out_beat_t w = '0);
    dir_row_t row;
    row.acc   = a;
    row.typed = typed;
    row.want  = w;
    dir_rows.push_back(row);
  endtask

  task automatic flag_error(input string msg);
    err_n++;
    if (err_n <= ERR_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s got %02h, want %02h", name, got, want));
  endtask

  // Present one input beat and hold it until it is taken, then either keep
  // valid up for the next beat of the burst or drop it for a random gap.
  task automatic send_access(input in_beat_t a);
    in_data_i  <= a;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_n++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and hold off until every result owed so far has come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (checked_n != sent_n) @(posedge clk_i);
  endtask

  // Sink side: switch between always ready, coin-flip ready and a choked
  // pattern, each for a random run of cycles.
  always @(posedge clk_i) begin : sink_pattern
    logic [31:0] raw;
    raw = $urandom;
    if (rx_run == 0) begin
      case (raw[9:8])
        2'd0:    rx_mode = SINK_OPEN;
        2'd1:    rx_mode = SINK_COIN;
        default: rx_mode = SINK_CHOKE;
      endcase
      rx_run = $urandom_range(4, 48);
    end else begin
      rx_run--;
    end
    case (rx_mode)
      SINK_OPEN: out_ready_i <= 1'b1;
      SINK_COIN: out_ready_i <= raw[0];
      default:   out_ready_i <= (raw[2:0] == 3'd0);
    endcase
  end

  // Scoreboard: advance the port registers on every accepted input beat and
  // queue what the block owes; compare each accepted output beat with the
  // oldest entry. Count cycles in which no beat moves for the watchdog.
  always @(posedge clk_i) begin : scoreboard
    out_beat_t   want;
    port_state_t nxt;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        want = apply_access(live_regs[in_data_i.port], in_data_i, nxt);
        live_regs[in_data_i.port] = nxt;
        // Typed rows override the prediction so the two are checked apart.
        if (accepted_n < dir_rows.size() && dir_rows[accepted_n].typed) begin
          want = dir_rows[accepted_n].want;
        end
        owed_reports_q.push_back(want);
        accepted_n++;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (owed_reports_q.size() == 0) begin
          flag_error($sformatf("result beat %0h with nothing owed", out_data_o));
        end else begin
          want = owed_reports_q.pop_front();
          check_field("control", out_data_o.control_out, want.control_out);
          check_field("status", out_data_o.status_out, want.status_out);
          check_field("data", out_data_o.data_out, want.data_out);
          check_field("bus_event", {5'b0, out_data_o.bus_event}, {5'b0, want.bus_event});
          check_field("bus_address", {1'b0, out_data_o.bus_address},
                      {1'b0, want.bus_address});
          check_field("bus_read", {7'b0, out_data_o.bus_read}, {7'b0, want.bus_read});
          check_field("fault", {7'b0, out_data_o.fault}, {7'b0, want.fault});
          ev_tally[want.bus_event]++;
          if (want.fault) fault_n++;
        end
        checked_n++;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // End the run if no beat moves on either side for too long.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    in_beat_t    cand;
    port_state_t nxt;
    out_beat_t   scratch;
    int unsigned tries;
    bit          dead;

    for (int p = 0; p < PORTS; p++) begin
      plan_regs[p] = '{control: 8'h00, status: ST_IDLE, data: 8'h00};
      live_regs[p] = plan_regs[p];
    end

    // Port 0: unused code after reset, then a write transfer ending in
    // stop-then-start, a read transfer with ack and without, and a stop.
    add_row(mk_access(OP_UNUSED, 1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF), 1'b1,
            mk_report(8'h00, ST_IDLE, 8'h00, EV_NONE, 7'h00, 1'b0, 1'b0));
    add_row(mk_access(OP_WRITE, 1'b0, 8'hA4, 1'b0, 1'b0, 8'h00), 1'b1,
            mk_report(8'h00, ST_IDLE, 8'hA4, EV_NONE, 7'h00, 1'b0, 1'b0));
    add_row(mk_access(OP_SET, 1'b0, M_EN | M_STA, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_SET, 1'b0, M_AA, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI | M_STA, 1'b1, 1'b0, 8'h00));
    add_row(mk_access(OP_WRITE, 1'b0, 8'hFF, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI, 1'b0, 1'b1, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI, 1'b0, 1'b1, 8'hFF));
    add_row(mk_access(OP_SET, 1'b0, M_STO | M_STA, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_WRITE, 1'b0, 8'h01, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI | M_STA, 1'b1, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI, 1'b0, 1'b0, 8'hFF));
    add_row(mk_access(OP_CLR, 1'b0, M_SI | M_AA, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI, 1'b0, 1'b0, 8'h5A));
    add_row(mk_access(OP_SET, 1'b0, M_STO, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b0, M_SI, 1'b1, 1'b1, 8'h00));
    // Port 1: full-mask set with the interrupt pending, full-mask clear,
    // then an address that nobody answers, which leaves an unhandled status.
    add_row(mk_access(OP_WRITE, 1'b1, 8'hFE, 1'b0, 1'b0, 8'h00), 1'b1,
            mk_report(8'h00, ST_IDLE, 8'hFE, EV_NONE, 7'h00, 1'b0, 1'b0));
    add_row(mk_access(OP_SET, 1'b1, 8'hFF, 1'b0, 1'b0, 8'h00), 1'b1,
            mk_report(8'hFF, ST_IDLE, 8'hFE, EV_NONE, 7'h00, 1'b0, 1'b0));
    add_row(mk_access(OP_CLR, 1'b1, 8'hFF, 1'b0, 1'b0, 8'h00), 1'b1,
            mk_report(M_SI, ST_IDLE, 8'hFE, EV_NONE, 7'h00, 1'b0, 1'b0));
    add_row(mk_access(OP_SET, 1'b1, M_STA, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b1, M_SI, 1'b0, 1'b0, 8'h00));
    add_row(mk_access(OP_CLR, 1'b1, M_SI | M_STA, 1'b0, 1'b0, 8'h00), 1'b1,
            mk_report(M_SI, ST_AW_NAK, 8'hFE, EV_ADDR, 7'h7F, 1'b0, 1'b0));
    add_row(mk_access(OP_CLR, 1'b1, M_SI, 1'b1, 1'b1, 8'hFF), 1'b1,
            mk_report(M_SI, ST_AW_NAK, 8'hFE, EV_NONE, 7'h00, 1'b0, 1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[k]) begin
      scratch = apply_access(plan_regs[dir_rows[k].acc.port], dir_rows[k].acc, nxt);
      plan_regs[dir_rows[k].acc.port] = nxt;
      send_access(dir_rows[k].acc);
    end
    hold_until_drained();

    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      // Redraw port 0 beats that would strand it in a dead status, except
      // in the closing stretch where those paths get exercised too.
      tries = 0;
      do begin
        cand = draw_access();
        scratch = apply_access(plan_regs[cand.port], cand, nxt);
        dead = !cand.port && (i < RANDOM_BEATS - UNGUARDED) &&
               !(nxt.status inside {ST_IDLE, ST_START, ST_AW_ACK, ST_DW_ACK,
                                    ST_AR_ACK, ST_DR_ACK, ST_DR_NAK});
        tries++;
      end while (dead && tries < 30);
      if (dead) begin
        cand.op = OP_UNUSED;
        scratch = apply_access(plan_regs[cand.port], cand, nxt);
      end
      plan_regs[cand.port] = nxt;
      send_access(cand);
      if (i == RANDOM_BEATS / 2) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (owed_reports_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", owed_reports_q.size()));
    end

    $display("Run: %0d register accesses (%0d directed), %0d results compared, %0d faults",
             sent_n, dir_rows.size(), checked_n, fault_n);
    $display("Bus events: addr %0d, write %0d, read %0d, stop %0d, restart %0d, stop+start %0d",
             ev_tally[EV_ADDR], ev_tally[EV_WRITE], ev_tally[EV_READ], ev_tally[EV_STOP],
             ev_tally[EV_RESTART], ev_tally[EV_STOP_START]);
    if (err_n == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
